### rtl/lpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpi_pkg;

    // Default number format: signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Status bits on the result tuser
    localparam int USER_PARALLEL  = 0;
    localparam int USER_SATURATED = 1;
    localparam int USER_BITS      = 2;

endpackage

`default_nettype wire

### rtl/line_plane_intersection.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Contents (lowest bits first)
// s_axis    in         first_x,y,z, second_x,y,z, plane_a,b,c,d
// m_axis    out        tdata: hit_x,y,z   tuser: parallel, saturated
//
// One item per cycle while the output is not stalled; the restoring divider
// resolves one quotient bit per stage (a Q16.16 quotient at the defaults).
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A stall at the output holds the whole pipeline; nothing is lost or repeated,
// and empty stages are not squeezed out.

module line_plane_intersection #(
    parameter int COORD_WIDTH = lpi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_s_axis_tvalid,
    output logic                                          o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // plane_a, plane_b, plane_c, plane_d
    input  wire logic [((10*COORD_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                          o_m_axis_tvalid,
    input  wire logic                                     i_m_axis_tready,
    // hit_x, hit_y, hit_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]            o_m_axis_tdata,
    // parallel_flag, saturated_flag
    output logic [lpi_pkg::USER_BITS-1:0]                 o_m_axis_tuser
);

    import lpi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2*W + 3;        // numerator / denominator
    localparam int NBW = DW + F;         // scaled dividend
    localparam int RW  = DW + 1;         // partial remainder
    localparam int SW  = 2*W + 2;        // coordinate sum before clamp
    localparam int ODW = ((3*W+7)/8)*8;

    localparam logic [W-1:0] K_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] K_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] C_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] C_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic adv;

    // Global advance: move when the output slot is free or being taken
    assign adv             = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // ---------------- stage 1: unpack, direction ----------------
    logic                 r1_vld;
    logic signed [W-1:0]  r1_pt  [0:2];
    logic signed [W:0]    r1_dir [0:2];
    logic signed [W-1:0]  r1_pl  [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_pt[i]  <= $signed(i_s_axis_tdata[i*W +: W]);
                r1_dir[i] <= (W+1)'($signed(i_s_axis_tdata[i*W +: W]))
                           - (W+1)'($signed(i_s_axis_tdata[(i+3)*W +: W]));
            end
            for (int i = 0; i < 4; i++) begin
                r1_pl[i] <= $signed(i_s_axis_tdata[(i+6)*W +: W]);
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic                  r2_vld;
    logic signed [2*W-1:0] r2_pp  [0:2];
    logic signed [2*W:0]   r2_pd  [0:2];
    logic signed [W-1:0]   r2_d;
    logic signed [W-1:0]   r2_pt  [0:2];
    logic signed [W:0]     r2_dir [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_pp[i]  <= (2*W)'(r1_pl[i]) * (2*W)'(r1_pt[i]);
                r2_pd[i]  <= (2*W+1)'(r1_pl[i]) * (2*W+1)'(r1_dir[i]);
                r2_pt[i]  <= r1_pt[i];
                r2_dir[i] <= r1_dir[i];
            end
            r2_d <= r1_pl[3];
        end
    end

    // ---------------- stage 3: numerator and denominator sums ----------------
    logic                 r3_vld;
    logic signed [DW-1:0] r3_num;
    logic signed [DW-1:0] r3_den;
    logic signed [W-1:0]  r3_pt  [0:2];
    logic signed [W:0]    r3_dir [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_num <= -(DW'(r2_d) <<< F) - DW'(r2_pp[0]) - DW'(r2_pp[1]) - DW'(r2_pp[2]);
            r3_den <= DW'(r2_pd[0]) + DW'(r2_pd[1]) + DW'(r2_pd[2]);
            for (int i = 0; i < 3; i++) begin
                r3_pt[i]  <= r2_pt[i];
                r3_dir[i] <= r2_dir[i];
            end
        end
    end

    // ---------------- stage 4: signs and magnitudes ----------------
    logic                r4_vld;
    logic                r4_zero;
    logic                r4_kneg;
    logic [DW-1:0]       r4_mn;
    logic [DW-1:0]       r4_md;
    logic signed [W-1:0] r4_pt  [0:2];
    logic signed [W:0]   r4_dir [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_zero <= (r3_den == '0);
            r4_kneg <= r3_num[DW-1] ^ r3_den[DW-1];
            r4_mn   <= r3_num[DW-1] ? DW'(-r3_num) : DW'(r3_num);
            r4_md   <= r3_den[DW-1] ? DW'(-r3_den) : DW'(r3_den);
            for (int i = 0; i < 3; i++) begin
                r4_pt[i]  <= r3_pt[i];
                r4_dir[i] <= r3_dir[i];
            end
        end
    end

    // ---------------- divider: entry stage plus one stage per quotient bit ----------------
    logic                r_dv_vld  [0:W];
    logic                r_dv_zero [0:W];
    logic                r_dv_kneg [0:W];
    logic                r_dv_ovf  [0:W];
    logic [RW-1:0]       r_dv_rem  [0:W];
    logic [W-1:0]        r_dv_lo   [0:W];
    logic [W-1:0]        r_dv_q    [0:W];
    logic [DW-1:0]       r_dv_md   [0:W];
    logic signed [W-1:0] r_dv_pt   [0:W][0:2];
    logic signed [W:0]   r_dv_dir  [0:W][0:2];

    logic [NBW-1:0]  n_dividend;
    logic [NBW-W-1:0] n_top;

    assign n_dividend = NBW'(r4_mn) << F;
    assign n_top      = n_dividend[NBW-1:W];

    // Entry: overflow when the quotient would reach 2^W
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (adv) begin
            r_dv_vld[0] <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_zero[0] <= r4_zero;
            r_dv_kneg[0] <= r4_kneg;
            r_dv_ovf[0]  <= (n_top >= r4_md);
            r_dv_rem[0]  <= RW'(n_top);
            r_dv_lo[0]   <= n_dividend[W-1:0];
            r_dv_q[0]    <= '0;
            r_dv_md[0]   <= r4_md;
            for (int i = 0; i < 3; i++) begin
                r_dv_pt[0][i]  <= r4_pt[i];
                r_dv_dir[0][i] <= r4_dir[i];
            end
        end
    end

    for (genvar j = 1; j <= W; j++) begin : g_div
        logic [RW-1:0] n_trial;
        logic          n_take;

        // Shift in the next dividend bit and try one subtract
        assign n_trial = {r_dv_rem[j-1][RW-2:0], r_dv_lo[j-1][W-j]};
        assign n_take  = (n_trial >= {1'b0, r_dv_md[j-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (adv) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_zero[j] <= r_dv_zero[j-1];
                r_dv_kneg[j] <= r_dv_kneg[j-1];
                r_dv_ovf[j]  <= r_dv_ovf[j-1];
                r_dv_rem[j]  <= n_take ? n_trial - {1'b0, r_dv_md[j-1]} : n_trial;
                r_dv_lo[j]   <= r_dv_lo[j-1];
                r_dv_q[j]    <= {r_dv_q[j-1][W-2:0], n_take};
                r_dv_md[j]   <= r_dv_md[j-1];
                for (int i = 0; i < 3; i++) begin
                    r_dv_pt[j][i]  <= r_dv_pt[j-1][i];
                    r_dv_dir[j][i] <= r_dv_dir[j-1][i];
                end
            end
        end
    end

    // ---------------- stage K: clamp and sign the quotient ----------------
    logic                r6_vld;
    logic                r6_zero;
    logic                r6_sat;
    logic signed [W-1:0] r6_kv;
    logic signed [W-1:0] r6_pt  [0:2];
    logic signed [W:0]   r6_dir [0:2];

    logic [W-1:0] n_bound;
    logic         n_ksat;
    logic [W-1:0] n_mag;

    assign n_bound = r_dv_kneg[W] ? K_NEG : K_POS;
    assign n_ksat  = r_dv_ovf[W] || (r_dv_q[W] > n_bound);
    assign n_mag   = n_ksat ? n_bound : r_dv_q[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (adv) begin
            r6_vld <= r_dv_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_zero <= r_dv_zero[W];
            r6_sat  <= n_ksat;
            r6_kv   <= r_dv_kneg[W] ? $signed(-n_mag) : $signed(n_mag);
            for (int i = 0; i < 3; i++) begin
                r6_pt[i]  <= r_dv_pt[W][i];
                r6_dir[i] <= r_dv_dir[W][i];
            end
        end
    end

    // ---------------- stage 7: k times direction ----------------
    logic                r7_vld;
    logic                r7_zero;
    logic                r7_sat;
    logic signed [2*W:0] r7_pk [0:2];
    logic signed [W-1:0] r7_pt [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (adv) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_zero <= r6_zero;
            r7_sat  <= r6_sat;
            for (int i = 0; i < 3; i++) begin
                r7_pk[i] <= (2*W+1)'(r6_kv) * (2*W+1)'(r6_dir[i]);
                r7_pt[i] <= r6_pt[i];
            end
        end
    end

    // ---------------- output stage: scale, add point, clamp ----------------
    logic signed [SW-1:0] n_sum  [0:2];
    logic [W-1:0]         n_hit  [0:2];
    logic [2:0]           n_clip;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SW'(r7_pk[i] >>> F) + SW'(r7_pt[i]);
            if (n_sum[i] > C_MAX) begin
                n_hit[i]  = K_POS;
                n_clip[i] = 1'b1;
            end else if (n_sum[i] < C_MIN) begin
                n_hit[i]  = K_NEG;
                n_clip[i] = 1'b1;
            end else begin
                n_hit[i]  = n_sum[i][W-1:0];
                n_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (adv) begin
            o_m_axis_tvalid <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r7_zero) begin
                o_m_axis_tdata <= '0;
            end else begin
                o_m_axis_tdata <= ODW'({n_hit[2], n_hit[1], n_hit[0]});
            end
            o_m_axis_tuser[USER_PARALLEL]  <= r7_zero;
            o_m_axis_tuser[USER_SATURATED] <= !r7_zero && (r7_sat || (n_clip != '0));
        end
    end

endmodule

`default_nettype wire

### bench/line_plane_intersection_tb.sv
`timescale 1ns / 1ps

module line_plane_intersection_tb;
    import lpi_pkg::*;

    localparam int CW       = 32;
    localparam int IN_W     = ((10*CW+7)/8)*8;
    localparam int OUT_W    = ((3*CW+7)/8)*8;
    localparam int N_RANDOM = 1830;
    localparam int MAX_CYC  = 2000000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] hit [3];
        logic                 parallel;
        logic                 saturated;
    } hit_point_t;

    // Predicts intersection points for accepted transfers and checks results in order
    class hit_scoreboard;
        hit_point_t pending[$];
        int         errors = 0;

        function void note_input(logic [IN_W-1:0] d);
            logic signed [CW-1:0] f [10];
            wide_t pt [3];
            wide_t dir [3];
            wide_t pl, num, den, mn, md, mag, bound, kv, s;
            logic neg;
            hit_point_t e;
            for (int i = 0; i < 10; i++) f[i] = d[CW*i +: CW];
            e.parallel = 0;
            e.saturated = 0;
            pl = f[9];
            num = -(pl <<< 16);
            den = 0;
            for (int i = 0; i < 3; i++) begin
                pt[i] = f[i];
                s = f[i+3];
                dir[i] = pt[i] - s;
                pl = f[i+6];
                num = num - pl * pt[i];
                den = den + pl * dir[i];
            end
            if (den == 0) begin
                // line parallel to plane or degenerate line
                for (int i = 0; i < 3; i++) e.hit[i] = '0;
                e.parallel = 1;
            end else begin
                neg = (num < 0) ^ (den < 0);
                mn = (num < 0) ? -num : num;
                md = (den < 0) ? -den : den;
                mag = (mn <<< 16) / md;
                bound = neg ? 128'sd2147483648 : 128'sd2147483647;
                if (mag > bound) begin
                    mag = bound;
                    e.saturated = 1;
                end
                kv = neg ? -mag : mag;
                for (int i = 0; i < 3; i++) begin
                    s = ((kv * dir[i]) >>> 16) + pt[i];
                    if (s > 128'sd2147483647) begin
                        s = 128'sd2147483647;
                        e.saturated = 1;
                    end else if (s < -128'sd2147483648) begin
                        s = -128'sd2147483648;
                        e.saturated = 1;
                    end
                    e.hit[i] = s[CW-1:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] d, logic [USER_BITS-1:0] u);
            hit_point_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer %h / %b", $time, d, u);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 3; i++)
                if (d[CW*i +: CW] !== e.hit[i]) begin
                    $display("%0t: hit[%0d] expected %h actual %h", $time, i, e.hit[i],
                             d[CW*i +: CW]);
                    errors++;
                end
            if (u[USER_PARALLEL] !== e.parallel) begin
                $display("%0t: parallel expected %b actual %b", $time, e.parallel,
                         u[USER_PARALLEL]);
                errors++;
            end
            if (u[USER_SATURATED] !== e.saturated) begin
                $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                         u[USER_SATURATED]);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [OUT_W-1:0]   m_tdata;
    logic [USER_BITS-1:0] m_tuser;

    hit_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;      // no idling in the closing stretch
    bit  hold_req = 0;   // long receiver hold-off request
    int  sent = 0;

    always #5 i_clk = ~i_clk;

    line_plane_intersection u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // Watch both channels for completed transfers
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) sb.note_input(s_tdata);
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("FAIL line_plane_intersection");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_tready <= 0;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 7);
                repeat (n) @(posedge i_clk);
            end else begin
                m_tready <= 1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic logic [CW-1:0] small_val();
        return CW'($urandom_range(0, 2097152)) - CW'(1048576);
    endfunction

    function automatic logic [IN_W-1:0] pack(logic [CW-1:0] v [10]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 10; i++) d[CW*i +: CW] = v[i];
        return d;
    endfunction

    // Offer one item and wait for its transfer; optional idle burst first
    task automatic send_item(logic [IN_W-1:0] d);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 7);
            repeat (n) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    function automatic logic [IN_W-1:0] random_item();
        logic [CW-1:0] v [10];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 10; i++) v[i] = small_val();
        case (kind)
            0, 1: for (int i = 0; i < 10; i++) v[i] = $urandom();
            2: begin
                // direction within plane z = const: parallel when plane_c*dz == 0
                v[5] = v[2];
                v[6] = 0;
                v[7] = 0;
            end
            3: for (int i = 0; i < 3; i++) v[i+3] = v[i];     // degenerate line
            4: for (int i = 0; i < 10; i++) v[i] = CW'($urandom_range(0, 64)) - CW'(32);
            default: ;
        endcase
        return pack(v);
    endfunction

    initial begin
        logic [CW-1:0] v [10];
        logic [CW-1:0] mx, mnv;
        mx  = 32'h7fff_ffff;
        mnv = 32'h8000_0000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: all zero (parallel)
        for (int i = 0; i < 10; i++) v[i] = 0;
        send_item(pack(v));
        // all max / all min / mixed extremes
        for (int i = 0; i < 10; i++) v[i] = mx;
        send_item(pack(v));
        for (int i = 0; i < 10; i++) v[i] = mnv;
        send_item(pack(v));
        for (int i = 0; i < 10; i++) v[i] = i[0] ? mx : mnv;
        send_item(pack(v));
        for (int i = 0; i < 10; i++) v[i] = i[0] ? mnv : mx;
        send_item(pack(v));
        for (int i = 0; i < 10; i++) v[i] = 32'hffff_ffff;
        v[3] = 32'h0001_0000;
        send_item(pack(v));
        // simple hit: line along z through (1,2,*), plane z = 3
        v = '{32'h10000, 32'h20000, 32'h50000, 32'h10000, 32'h20000, 32'h40000,
              0, 0, 32'h10000, 32'hfffd0000};
        send_item(pack(v));
        // degenerate line: equal points
        v = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
              32'h10000, 32'h10000, 32'h10000, 32'h10000};
        send_item(pack(v));
        // tiny denominator, large numerator: k saturates
        v = '{0, 0, 0, 0, 0, 32'hffffffff, 0, 0, 32'h1, mx};
        send_item(pack(v));
        v = '{0, 0, 0, 0, 0, 32'h1, 0, 0, 32'h1, mx};
        send_item(pack(v));
        // coordinate clamp: far point pushed past the range
        v = '{mx, mx, mx, mnv, mnv, mnv, 32'h1, 0, 0, mnv};
        send_item(pack(v));
        v = '{mnv, 0, 0, mx, 0, 0, 32'h10000, 0, 0, 32'h10000};
        send_item(pack(v));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_req = 1;
            if (n == N_RANDOM - 200) quiet = 1;
            send_item(random_item());
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS line_plane_intersection");
        else
            $display("FAIL line_plane_intersection");
        $finish;
    end

endmodule

### sim.f
rtl/lpi_pkg.sv
rtl/line_plane_intersection.sv
bench/line_plane_intersection_tb.sv
